FILE: src/rvf_pkg.sv
// Shared types, constants and helpers of the ring repeated-vertex filter.
package rvf_pkg;

  // Configuration port geometry and register decode.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic REG_TOLERANCE = 1'b0;

  // Field widths that the result format fixes.
  localparam int unsigned TOL_W = 31;
  localparam int unsigned KEPT_OUT_W = 13;
  localparam int unsigned REMOVED_W = 16;
  localparam int unsigned KEPT_OUT_MAX = 8191;
  localparam logic [REMOVED_W-1:0] REMOVED_MAX = 16'hFFFF;

  // Minimum kept vertices of a closed ring and of an open run.
  localparam int unsigned MIN_CLOSED = 3;
  localparam int unsigned MIN_OPEN = 2;

  // Depth of the command queue between front and back.
  localparam int unsigned CMD_DEPTH = 2;

  typedef enum logic [1:0] {
    VERDICT_REPAIRED   = 2'd0,
    VERDICT_CLEAN      = 2'd1,
    VERDICT_DEGENERATE = 2'd2,
    VERDICT_PENDING    = 2'd3
  } verdict_e;

  typedef enum logic {
    KIND_VERTEX  = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  // Control part of one command: which results to emit and the summary fields.
  typedef struct packed {
    logic                  v1_en;
    logic                  v2_en;
    logic                  sum_en;
    logic [KEPT_OUT_W-1:0] kept;
    logic                  few;
    verdict_e              verdict;
    logic [REMOVED_W-1:0]  removed;
  } rvf_cmd_t;

  // Saturating increment of the removed-vertex count.
  function automatic logic [REMOVED_W-1:0] removed_inc(input logic [REMOVED_W-1:0] v);
    return (v == REMOVED_MAX) ? v : v + 16'd1;
  endfunction

endpackage

FILE: src/rvf_cmd_fifo.sv
// Small register-based queue that carries commands from the front to the back.
module rvf_cmd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: src/rvf_front.sv
// Front end: tracks the held and first vertex of a ring and classifies each vertex.
module rvf_front #(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned MAX_RING_VERTICES = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [rvf_pkg::TOL_W-1:0]    tol_i,
  input  logic                         accept_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic                         ring_closed_i,
  input  logic                         ring_end_i,
  input  logic                         entity_end_i,
  output logic                         cmd_push_o,
  output rvf_pkg::rvf_cmd_t            cmd_o,
  output logic signed [COORD_BITS-1:0] v1_x_o,
  output logic signed [COORD_BITS-1:0] v1_y_o,
  output logic signed [COORD_BITS-1:0] v2_x_o,
  output logic signed [COORD_BITS-1:0] v2_y_o
);

  import rvf_pkg::*;

  localparam int unsigned DW  = (COORD_BITS > TOL_W) ? COORD_BITS : TOL_W;
  localparam int unsigned KW  = $clog2(MAX_RING_VERTICES + 1);
  localparam int unsigned KCW = (KW > KEPT_OUT_W) ? KW : KEPT_OUT_W;
  localparam logic [KW-1:0] KMAX = KW'(MAX_RING_VERTICES);

  // Chebyshev distance within tolerance.
  function automatic logic near_f(input logic signed [COORD_BITS-1:0] ax,
                                  input logic signed [COORD_BITS-1:0] ay,
                                  input logic signed [COORD_BITS-1:0] bx,
                                  input logic signed [COORD_BITS-1:0] by,
                                  input logic [TOL_W-1:0] tol);
    logic signed [COORD_BITS:0] dx, dy, ndx, ndy;
    logic [COORD_BITS-1:0] adx, ady, dmax;
    logic [DW-1:0] de, te;
    dx   = {ax[COORD_BITS-1], ax} - {bx[COORD_BITS-1], bx};
    dy   = {ay[COORD_BITS-1], ay} - {by[COORD_BITS-1], by};
    ndx  = -dx;
    ndy  = -dy;
    adx  = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    ady  = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    dmax = (adx > ady) ? adx : ady;
    de   = DW'(dmax);
    te   = DW'(tol);
    return de <= te;
  endfunction

  logic signed [COORD_BITS-1:0] held_x_q, held_y_q, first_x_q, first_y_q;
  logic signed [COORD_BITS-1:0] held_x_d, held_y_d, first_x_d, first_y_d;
  logic held_valid_q, held_valid_d;
  logic [KW-1:0] kept_q, kept_d;
  logic [REMOVED_W-1:0] removed_q, removed_d;
  logic degen_q, degen_d;

  logic start, rend, near_held, near_close, close_drop, few, degen_new;
  logic v1_en, v2_en;
  logic [KW-1:0] kept1, kept2;
  logic [KCW-1:0] kept_wide;
  logic [REMOVED_W-1:0] rem1, rem2;
  logic signed [COORD_BITS-1:0] new_x, new_y;
  verdict_e verdict;

  // Classification of the incoming vertex against the held and first vertex.
  always_comb begin
    start     = !held_valid_q;
    rend      = ring_end_i || entity_end_i;
    near_held = held_valid_q &&
                near_f(point_x_i, point_y_i, held_x_q, held_y_q, tol_i);
    v1_en     = held_valid_q && !near_held;
    new_x     = near_held ? held_x_q : point_x_i;
    new_y     = near_held ? held_y_q : point_y_i;
    rem1      = near_held ? removed_inc(removed_q) : removed_q;

    if (start) begin
      kept1 = KW'(1);
    end else if (v1_en && (kept_q < KMAX)) begin
      kept1 = kept_q + KW'(1);
    end else begin
      kept1 = kept_q;
    end

    // The closing test uses the vertex that ends up held.
    near_close = near_held ? near_f(held_x_q, held_y_q, first_x_q, first_y_q, tol_i)
                           : near_f(point_x_i, point_y_i, first_x_q, first_y_q, tol_i);
    close_drop = rend && ring_closed_i && !start && (kept1 > KW'(1)) && near_close;
    kept2      = (close_drop && (kept1 < KMAX)) ? kept1 - KW'(1) : kept1;
    rem2       = close_drop ? removed_inc(rem1) : rem1;
    v2_en      = rend && !close_drop;
    few        = ring_closed_i ? (kept2 < KW'(MIN_CLOSED)) : (kept2 < KW'(MIN_OPEN));
    degen_new  = degen_q || few;

    if (!entity_end_i) begin
      verdict = VERDICT_PENDING;
    end else if (degen_new) begin
      verdict = VERDICT_DEGENERATE;
    end else if (rem2 == '0) begin
      verdict = VERDICT_CLEAN;
    end else begin
      verdict = VERDICT_REPAIRED;
    end

    kept_wide = KCW'(kept2);
  end

  // Command toward the back end.
  always_comb begin
    cmd_push_o     = accept_i && (v1_en || rend);
    cmd_o.v1_en    = v1_en;
    cmd_o.v2_en    = v2_en;
    cmd_o.sum_en   = rend;
    cmd_o.kept     = (kept_wide > KCW'(KEPT_OUT_MAX)) ? KEPT_OUT_W'(KEPT_OUT_MAX)
                                                      : kept_wide[KEPT_OUT_W-1:0];
    cmd_o.few      = few;
    cmd_o.verdict  = verdict;
    cmd_o.removed  = rem2;
    v1_x_o         = held_x_q;
    v1_y_o         = held_y_q;
    v2_x_o         = new_x;
    v2_y_o         = new_y;
  end

  // Next ring and entity state.
  always_comb begin
    held_valid_d = held_valid_q;
    kept_d       = kept_q;
    removed_d    = removed_q;
    degen_d      = degen_q;
    held_x_d     = held_x_q;
    held_y_d     = held_y_q;
    first_x_d    = first_x_q;
    first_y_d    = first_y_q;
    if (accept_i) begin
      held_x_d  = new_x;
      held_y_d  = new_y;
      first_x_d = start ? point_x_i : first_x_q;
      first_y_d = start ? point_y_i : first_y_q;
      if (rend) begin
        held_valid_d = 1'b0;
        kept_d       = '0;
        removed_d    = entity_end_i ? '0 : rem2;
        degen_d      = entity_end_i ? 1'b0 : degen_new;
      end else begin
        held_valid_d = 1'b1;
        kept_d       = kept1;
        removed_d    = rem1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      kept_q       <= '0;
      removed_q    <= '0;
      degen_q      <= 1'b0;
    end else begin
      held_valid_q <= held_valid_d;
      kept_q       <= kept_d;
      removed_q    <= removed_d;
      degen_q      <= degen_d;
    end
  end

  // Vertex coordinates are only read while the held vertex is valid.
  always_ff @(posedge clk_i) begin
    held_x_q  <= held_x_d;
    held_y_q  <= held_y_d;
    first_x_q <= first_x_d;
    first_y_q <= first_y_d;
  end

endmodule

FILE: src/rvf_back.sv
// Back end: expands each command into its result records, one per cycle while pop is high.
module rvf_back #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cmd_valid_i,
  input  rvf_pkg::rvf_cmd_t                   cmd_i,
  input  logic signed [COORD_BITS-1:0]        v1_x_i,
  input  logic signed [COORD_BITS-1:0]        v1_y_i,
  input  logic signed [COORD_BITS-1:0]        v2_x_i,
  input  logic signed [COORD_BITS-1:0]        v2_y_i,
  output logic                                cmd_pop_o,
  input  logic                                pop_i,
  output logic                                empty_o,
  output logic                                result_kind_o,
  output logic signed [COORD_BITS-1:0]        out_x_o,
  output logic signed [COORD_BITS-1:0]        out_y_o,
  output logic                                run_last_o,
  output logic [rvf_pkg::KEPT_OUT_W-1:0]      kept_count_o,
  output logic                                too_few_o,
  output logic [1:0]                          verdict_o,
  output logic [rvf_pkg::REMOVED_W-1:0]       removed_total_o
);

  import rvf_pkg::*;

  logic [2:0] done_q, done_d, remain, pick;
  logic out_valid_q, out_valid_d;
  logic load, last;

  kind_e                  kind_q, kind_d;
  logic signed [COORD_BITS-1:0] x_q, x_d, y_q, y_d;
  logic                   run_last_q, run_last_d;
  logic [KEPT_OUT_W-1:0]  kept_q, kept_d;
  logic                   few_q, few_d;
  verdict_e               verdict_q, verdict_d;
  logic [REMOVED_W-1:0]   removed_q, removed_d;

  // Pick the oldest result of the head command that is not yet sent.
  always_comb begin
    remain = {cmd_i.sum_en, cmd_i.v2_en, cmd_i.v1_en} & ~done_q;
    if (remain[0]) begin
      pick = 3'b001;
    end else if (remain[1]) begin
      pick = 3'b010;
    end else begin
      pick = 3'b100;
    end
    last      = ((remain & ~pick) == 3'b000);
    load      = cmd_valid_i && (!out_valid_q || pop_i);
    cmd_pop_o = load && last;

    done_d = done_q;
    if (load) begin
      done_d = last ? 3'b000 : (done_q | pick);
    end

    if (load) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Result record for the picked slot.
  always_comb begin
    kind_d     = kind_q;
    x_d        = x_q;
    y_d        = y_q;
    run_last_d = run_last_q;
    kept_d     = kept_q;
    few_d      = few_q;
    verdict_d  = verdict_q;
    removed_d  = removed_q;
    if (load) begin
      if (pick[2]) begin
        kind_d     = KIND_SUMMARY;
        x_d        = '0;
        y_d        = '0;
        run_last_d = 1'b1;
        kept_d     = cmd_i.kept;
        few_d      = cmd_i.few;
        verdict_d  = cmd_i.verdict;
        removed_d  = cmd_i.removed;
      end else begin
        kind_d     = KIND_VERTEX;
        x_d        = pick[0] ? v1_x_i : v2_x_i;
        y_d        = pick[0] ? v1_y_i : v2_y_i;
        run_last_d = 1'b0;
        kept_d     = '0;
        few_d      = 1'b0;
        verdict_d  = VERDICT_PENDING;
        removed_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 3'b000;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    x_q        <= x_d;
    y_q        <= y_d;
    run_last_q <= run_last_d;
    kept_q     <= kept_d;
    few_q      <= few_d;
    verdict_q  <= verdict_d;
    removed_q  <= removed_d;
  end

  assign empty_o         = !out_valid_q;
  assign result_kind_o   = kind_q;
  assign out_x_o         = x_q;
  assign out_y_o         = y_q;
  assign run_last_o      = run_last_q;
  assign kept_count_o    = kept_q;
  assign too_few_o       = few_q;
  assign verdict_o       = verdict_q;
  assign removed_total_o = removed_q;

endmodule

FILE: src/ring_repeated_vertex_filter_top.sv
// Top level of the ring repeated-vertex filter: config port, front, queue and back.
//
//   Channel  Handshake             Contents
//   input    push / full           point_x_i, point_y_i, ring_closed_i, ring_end_i,
//                                  entity_end_i
//   result   empty / pop           result_kind_o, out_x_o, out_y_o, run_last_o,
//                                  kept_count_o, too_few_o, verdict_o, removed_total_o
//   config   psel/penable/pwrite   tolerance at byte address 0, pready always high
//
// The front takes one vertex per cycle while full is low and pushes a command for
// every vertex that yields a result; the back sends one result per cycle from the
// output register while pop is high. A vertex makes zero to three results, so the
// sustained rate is set by the single result port.
// full rises only when the two-entry command queue is full. Reset clears the
// ring and entity state and the tolerance; no clearing pass follows.
module ring_repeated_vertex_filter_top #(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned MAX_RING_VERTICES = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rvf_pkg::PADDR_W-1:0]         paddr,
  input  logic [rvf_pkg::PDATA_W-1:0]         pwdata,
  output logic [rvf_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  // Input vertices.
  input  logic                                push,
  output logic                                full,
  input  logic signed [COORD_BITS-1:0]        point_x_i,
  input  logic signed [COORD_BITS-1:0]        point_y_i,
  input  logic                                ring_closed_i,
  input  logic                                ring_end_i,
  input  logic                                entity_end_i,
  // Results.
  output logic                                empty,
  input  logic                                pop,
  output logic                                result_kind_o,
  output logic signed [COORD_BITS-1:0]        out_x_o,
  output logic signed [COORD_BITS-1:0]        out_y_o,
  output logic                                run_last_o,
  output logic [rvf_pkg::KEPT_OUT_W-1:0]      kept_count_o,
  output logic                                too_few_o,
  output logic [1:0]                          verdict_o,
  output logic [rvf_pkg::REMOVED_W-1:0]       removed_total_o
);

  import rvf_pkg::*;

  localparam int unsigned CMD_W = $bits(rvf_cmd_t) + 4 * COORD_BITS;

  logic [TOL_W-1:0] tol_q, tol_d;
  logic cfg_write, accept, cmd_push, cmd_valid, cmd_pop;
  rvf_cmd_t cmd_w, cmd_r;
  logic signed [COORD_BITS-1:0] v1_x_w, v1_y_w, v2_x_w, v2_y_w;
  logic signed [COORD_BITS-1:0] v1_x_r, v1_y_r, v2_x_r, v2_y_r;
  logic [CMD_W-1:0] wdata, rdata;

  // Tolerance register behind the configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_TOLERANCE);
  assign tol_d     = cfg_write ? pwdata[TOL_W-1:0] : tol_q;
  assign prdata    = (paddr[2] == REG_TOLERANCE) ? {1'b0, tol_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else begin
      tol_q <= tol_d;
    end
  end

  // A vertex request is taken whenever the command queue has room.
  assign accept = push && !full;

  rvf_front #(
    .COORD_BITS       (COORD_BITS),
    .MAX_RING_VERTICES(MAX_RING_VERTICES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tol_i        (tol_q),
    .accept_i     (accept),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .ring_closed_i(ring_closed_i),
    .ring_end_i   (ring_end_i),
    .entity_end_i (entity_end_i),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_w),
    .v1_x_o       (v1_x_w),
    .v1_y_o       (v1_y_w),
    .v2_x_o       (v2_x_w),
    .v2_y_o       (v2_y_w)
  );

  assign wdata = {cmd_w, v1_x_w, v1_y_w, v2_x_w, v2_y_w};

  rvf_cmd_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(wdata),
    .full_o (full),
    .pop_i  (cmd_pop),
    .valid_o(cmd_valid),
    .rdata_o(rdata)
  );

  assign {cmd_r, v1_x_r, v1_y_r, v2_x_r, v2_y_r} = rdata;

  rvf_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd_r),
    .v1_x_i         (v1_x_r),
    .v1_y_i         (v1_y_r),
    .v2_x_i         (v2_x_r),
    .v2_y_i         (v2_y_r),
    .cmd_pop_o      (cmd_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .result_kind_o  (result_kind_o),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .run_last_o     (run_last_o),
    .kept_count_o   (kept_count_o),
    .too_few_o      (too_few_o),
    .verdict_o      (verdict_o),
    .removed_total_o(removed_total_o)
  );

endmodule

FILE: tb/sv/ring_repeated_vertex_filter_top_test.sv
// Self-checking testbench for the ring repeated-vertex filter top level.
`timescale 1ns / 100ps

module ring_repeated_vertex_filter_top_test;
  import rvf_pkg::*;

  localparam int COORD_W = 32;
  localparam int unsigned MAX_RING = 4096;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PRINT_LIMIT = 20;
  localparam int ITEMS_PER_PHASE = 50;
  localparam logic [PADDR_W-1:0] TOL_ADDR = PADDR_W'(REG_TOLERANCE) << 2;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;

  // One vertex request as the sender presents it.
  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      closed;
    logic                      ring_end;
    logic                      entity_end;
  } vertex_t;

  // One result record as the block sends it.
  typedef struct {
    kind_e                     kind;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
    logic [KEPT_OUT_W-1:0]     kept;
    logic                      few;
    verdict_e                  verdict;
    logic [REMOVED_W-1:0]      removed;
  } result_t;

  // Clock, reset and block ports.
  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [PADDR_W-1:0]        paddr = '0;
  logic [PDATA_W-1:0]        pwdata = '0;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;
  logic                      push = 1'b0;
  logic                      full;
  logic signed [COORD_W-1:0] point_x_i = '0;
  logic signed [COORD_W-1:0] point_y_i = '0;
  logic                      ring_closed_i = 1'b0;
  logic                      ring_end_i = 1'b0;
  logic                      entity_end_i = 1'b0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic                      result_kind_o;
  logic signed [COORD_W-1:0] out_x_o;
  logic signed [COORD_W-1:0] out_y_o;
  logic                      run_last_o;
  logic [KEPT_OUT_W-1:0]     kept_count_o;
  logic                      too_few_o;
  logic [1:0]                verdict_o;
  logic [REMOVED_W-1:0]      removed_total_o;

  // Pending requests, expected results and run statistics.
  vertex_t pending_q[$];
  result_t expected_q[$];
  int      send_idle_pct = 0;
  int      pop_stall_pct = 0;
  int      queued_cnt = 0;
  int      sent_cnt = 0;
  int      results_seen = 0;
  int      entities_seen = 0;
  int      tol_writes = 0;
  int      mismatch_cnt = 0;
  int      cycle_cnt = 0;

  // Filter state mirrored from the block; reset zeroes all of it but the held and first coordinates.
  logic signed [COORD_W-1:0] held_x = '0;
  logic signed [COORD_W-1:0] held_y = '0;
  logic signed [COORD_W-1:0] first_x = '0;
  logic signed [COORD_W-1:0] first_y = '0;
  logic                      held_valid = 1'b0;
  int unsigned               ring_kept = 0;
  logic [REMOVED_W-1:0]      entity_removed = '0;
  logic                      entity_degenerate = 1'b0;
  logic [TOL_W-1:0]          tolerance_q = '0;

  ring_repeated_vertex_filter_top #(
    .COORD_BITS(COORD_W),
    .MAX_RING_VERTICES(MAX_RING)
  ) i_dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Chebyshev distance test against the current tolerance, in 64 bits.
  function automatic logic within_tol(input logic signed [COORD_W-1:0] ax, ay, bx, by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return ((dx > dy) ? dx : dy) <= longint'(tolerance_q);
  endfunction

  task automatic bump_removed();
    if (entity_removed != REMOVED_MAX) entity_removed++;
  endtask

  task automatic emit_vertex(input logic signed [COORD_W-1:0] x, y);
    result_t r;
    r.kind = KIND_VERTEX;
    r.x = x;
    r.y = y;
    r.last = 1'b0;
    r.kept = '0;
    r.few = 1'b0;
    r.verdict = VERDICT_PENDING;
    r.removed = '0;
    expected_q.insert(expected_q.size(), r);
  endtask

  // Work out the results of one accepted request and advance the mirrored state.
  task automatic predict_request(input vertex_t v);
    int unsigned minimum;
    result_t     r;
    if (!held_valid) begin
      held_x = v.x;
      held_y = v.y;
      first_x = v.x;
      first_y = v.y;
      held_valid = 1'b1;
      ring_kept = 1;
    end else if (within_tol(v.x, v.y, held_x, held_y)) begin
      bump_removed();
    end else begin
      emit_vertex(held_x, held_y);
      held_x = v.x;
      held_y = v.y;
      if (ring_kept < MAX_RING) ring_kept++;
    end

    // An entity end closes the ring even without a ring end.
    if (v.ring_end || v.entity_end) begin
      minimum = v.closed ? MIN_CLOSED : MIN_OPEN;
      if (v.closed && ring_kept > 1 && within_tol(held_x, held_y, first_x, first_y)) begin
        if (ring_kept < MAX_RING) ring_kept--;
        bump_removed();
      end else begin
        emit_vertex(held_x, held_y);
      end
      r.kind = KIND_SUMMARY;
      r.x = '0;
      r.y = '0;
      r.last = 1'b1;
      r.kept = KEPT_OUT_W'((ring_kept > KEPT_OUT_MAX) ? KEPT_OUT_MAX : ring_kept);
      r.few = ring_kept < minimum;
      if (r.few) entity_degenerate = 1'b1;
      r.verdict = VERDICT_PENDING;
      if (v.entity_end) begin
        r.verdict = entity_degenerate ? VERDICT_DEGENERATE :
                    (entity_removed == 0) ? VERDICT_CLEAN : VERDICT_REPAIRED;
      end
      r.removed = entity_removed;
      expected_q.insert(expected_q.size(), r);
      held_valid = 1'b0;
      held_x = '0;
      held_y = '0;
      first_x = '0;
      first_y = '0;
      ring_kept = 0;
      if (v.entity_end) begin
        entity_removed = '0;
        entity_degenerate = 1'b0;
      end
    end
  endtask

  task automatic note_mismatch(input string what, input longint got, input longint want);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_LIMIT) begin
      $display("MISMATCH %s at result %0d: got %0d, expected %0d",
               what, results_seen, got, want);
    end
  endtask

  // Compare one accepted result with the oldest expectation.
  task automatic check_result();
    result_t want;
    if (expected_q.size() == 0) begin
      note_mismatch("result with none expected, kind", result_kind_o, 0);
      return;
    end
    want = expected_q.pop_front();
    results_seen++;
    if (want.kind == KIND_SUMMARY && want.verdict != VERDICT_PENDING) entities_seen++;
    if (result_kind_o !== want.kind) note_mismatch("result_kind", result_kind_o, want.kind);
    if (out_x_o !== want.x) note_mismatch("out_x", out_x_o, want.x);
    if (out_y_o !== want.y) note_mismatch("out_y", out_y_o, want.y);
    if (run_last_o !== want.last) note_mismatch("run_last", run_last_o, want.last);
    if (kept_count_o !== want.kept) note_mismatch("kept_count", kept_count_o, want.kept);
    if (too_few_o !== want.few) note_mismatch("too_few", too_few_o, want.few);
    if (verdict_o !== want.verdict) note_mismatch("verdict", verdict_o, want.verdict);
    if (removed_total_o !== want.removed) begin
      note_mismatch("removed_total", removed_total_o, want.removed);
    end
  endtask

  task automatic queue_vertex(input logic signed [COORD_W-1:0] x, y,
                              input logic closed, ring_end, entity_end);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.closed = closed;
    v.ring_end = ring_end;
    v.entity_end = entity_end;
    pending_q.insert(pending_q.size(), v);
    queued_cnt++;
  endtask

  // A coordinate from the extremes, the full range or a small window.
  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(7))
      0: return $urandom_range(1) ? COORD_MIN : COORD_MAX;
      1: return $urandom_range(1) ? 32'sd0 : -32'sd1;
      2, 3, 4: return $urandom();
      default: return 32'($urandom_range(400)) - 32'sd200;
    endcase
  endfunction

  // A coordinate near base: equal, at the tolerance edge, just past it or inside.
  function automatic logic signed [COORD_W-1:0] jitter(input logic signed [COORD_W-1:0] base);
    longint d;
    case ($urandom_range(3))
      0: d = 0;
      1: d = longint'(tolerance_q);
      2: d = longint'(tolerance_q) + 1;
      default: d = $urandom_range((tolerance_q > 1000) ? 1000 : tolerance_q);
    endcase
    if ($urandom_range(1)) d = -d;
    return base + 32'(d);
  endfunction

  // One entity of one to three rings with repeats, closing points and some stray flags.
  task automatic queue_entity();
    int                        n_rings;
    int                        n_verts;
    logic                      closed;
    logic                      rend;
    logic                      eend;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] fx;
    logic signed [COORD_W-1:0] fy;
    n_rings = $urandom_range(1, 3);
    px = '0;
    py = '0;
    fx = '0;
    fy = '0;
    for (int r = 0; r < n_rings; r++) begin
      n_verts = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 9);
      closed = 1'($urandom_range(1));
      for (int k = 0; k < n_verts; k++) begin
        if (k == 0) begin
          px = pick_coord();
          py = pick_coord();
          fx = px;
          fy = py;
        end else if (closed && k == n_verts - 1 && $urandom_range(1)) begin
          px = jitter(fx);
          py = jitter(fy);
        end else if ($urandom_range(2) != 0) begin
          px = jitter(px);
          py = jitter(py);
        end else begin
          px = pick_coord();
          py = pick_coord();
        end
        rend = (k == n_verts - 1);
        eend = rend && (r == n_rings - 1);
        if (eend && $urandom_range(5) == 0) begin
          rend = 1'b0;
        end else if (!rend && $urandom_range(24) == 0) begin
          rend = 1'b1;
        end
        queue_vertex(px, py, (rend || eend) ? closed : 1'($urandom_range(1)), rend, eend);
      end
    end
  endtask

  // Wait until every request is taken and every result has come back.
  task automatic drain();
    while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write through the configuration port: setup, then access until ready.
  task automatic write_tolerance(input logic [PDATA_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TOL_ADDR;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tolerance_q = value[TOL_W-1:0];
    tol_writes++;
  endtask

  // Sender: predict each accepted request, then offer the next one or idle.
  // A request that is still waiting stays on the ports until it is taken.
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      predict_request(pending_q[0]);
      void'(pending_q.pop_front());
      sent_cnt++;
    end
    if (rst_ni && pending_q.size() != 0 &&
        ((push && full) || $urandom_range(99) >= send_idle_pct)) begin
      push <= 1'b1;
      point_x_i <= pending_q[0].x;
      point_y_i <= pending_q[0].y;
      ring_closed_i <= pending_q[0].closed;
      ring_end_i <= pending_q[0].ring_end;
      entity_end_i <= pending_q[0].entity_end;
    end else begin
      push <= 1'b0;
    end
  end

  // Receiver: check each accepted result, then pop or stall.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) check_result();
    pop <= rst_ni && ($urandom_range(99) >= pop_stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               CYCLE_LIMIT, expected_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    logic [PDATA_W-1:0] tol_word;
    int                 goal;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero tolerance, with the upper data bit set to show it is ignored.
    write_tolerance(32'h8000_0000);
    // Entity end without ring end, on a one-vertex ring.
    queue_vertex(32'sd0, 32'sd0, 1'b0, 1'b0, 1'b1);
    // Open run of extreme points, then a closed ring with a repeat and a closing drop.
    queue_vertex(COORD_MIN, COORD_MAX, 1'b1, 1'b0, 1'b0);
    queue_vertex(COORD_MAX, COORD_MIN, 1'b0, 1'b1, 1'b0);
    queue_vertex(32'sd5, 32'sd5, 1'b1, 1'b0, 1'b0);
    queue_vertex(32'sd5, 32'sd5, 1'b1, 1'b0, 1'b0);
    queue_vertex(32'sd9, 32'sd5, 1'b1, 1'b0, 1'b0);
    queue_vertex(32'sd9, 32'sd9, 1'b1, 1'b0, 1'b0);
    queue_vertex(32'sd5, 32'sd5, 1'b1, 1'b1, 1'b1);
    // Clean open run: nothing removed.
    queue_vertex(32'sd1, 32'sd2, 1'b0, 1'b0, 1'b0);
    queue_vertex(32'sd3, 32'sd4, 1'b0, 1'b0, 1'b0);
    queue_vertex(-32'sd1, -32'sd1, 1'b0, 1'b0, 1'b1);
    // Closed ring that falls to two vertices, then a closed ring of one vertex.
    queue_vertex(32'sd0, 32'sd0, 1'b1, 1'b0, 1'b0);
    queue_vertex(32'sd7, 32'sd0, 1'b1, 1'b0, 1'b0);
    queue_vertex(32'sd0, 32'sd0, 1'b1, 1'b1, 1'b0);
    queue_vertex(-32'sd1, -32'sd1, 1'b1, 1'b1, 1'b1);
    // Repeated extreme point, then the far corner.
    queue_vertex(COORD_MAX, COORD_MAX, 1'b0, 1'b0, 1'b0);
    queue_vertex(COORD_MAX, COORD_MAX, 1'b0, 1'b0, 1'b0);
    queue_vertex(COORD_MIN, COORD_MIN, 1'b0, 1'b1, 1'b1);
    drain();

    // Random entities across tolerance settings and idling patterns.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: tol_word = 32'd0;
        1: tol_word = 32'd1;
        2: tol_word = 32'd3;
        3: tol_word = 32'h7FFF_FFFF;
        4: tol_word = 32'd100;
        5: tol_word = 32'h7FFF_FFFE;
        6: tol_word = $urandom_range(5000);
        default: tol_word = $urandom();
      endcase
      tol_word[PDATA_W-1] = 1'($urandom_range(1));
      write_tolerance(tol_word);
      case (p % 4)
        0: begin send_idle_pct = 0; pop_stall_pct = 0; end
        1: begin send_idle_pct = 56; pop_stall_pct = 0; end
        2: begin send_idle_pct = 0; pop_stall_pct = 56; end
        default: begin send_idle_pct = 9; pop_stall_pct = 9; end
      endcase
      goal = queued_cnt + ITEMS_PER_PHASE;
      while (queued_cnt < goal) queue_entity();
      drain();
    end

    if (expected_q.size() != 0) note_mismatch("results never sent", 0, expected_q.size());
    $display("Sent %0d vertices in %0d entities; checked %0d results.",
             sent_cnt, entities_seen, results_seen);
    $display("Tolerance written %0d times; %0d mismatches.", tol_writes, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/rvf_pkg.sv
src/rvf_cmd_fifo.sv
src/rvf_front.sv
src/rvf_back.sv
src/ring_repeated_vertex_filter_top.sv
tb/sv/ring_repeated_vertex_filter_top_test.sv
